[src/rfop_pkg.sv]
// Shared constants and codes for the ring FIFO with full-queue policy.
`timescale 1ns / 1ps

package rfop_pkg;

  // Default sizing of the entry store
  localparam int DEPTH_DEF  = 16;
  localparam int WORD_W_DEF = 32;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = 32;
  localparam int CAP_W    = 5;
  localparam int POLICY_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Full-queue policy codes; any other code rejects without counting
  localparam logic [POLICY_W-1:0] POLICY_DROP_OLDEST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_REJECT_CNT  = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CAP_W-1:0]    CAPACITY_RST = 5'd16;
  localparam logic [POLICY_W-1:0] POLICY_RST   = 2'd0;

endpackage

[src/rfop_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rfop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ring_fifo_overflow_policy_top.sv]
// Top level of the ring FIFO with configurable capacity and full-queue policy.
`timescale 1ns / 1ps

// Ring FIFO of message words with a usable capacity and a policy for adds to a
// full queue (drop oldest, reject and count, reject only). Each request (query,
// add, remove, clear) gives exactly one result. The request waits in the input
// register until it moves on; as it moves on, pointers, fill level and counters
// are updated, the entry store is written and read, and the result register
// loads and holds until taken. One request is taken every cycle for as long as
// results are taken; the rate is set by the single write and single registered
// read of the entry store per cycle.
// The store needs no clearing pass after reset. Configuration writes are taken
// at any time but belong in idle periods.

module ring_fifo_overflow_policy_top #(
  parameter int DEPTH  = rfop_pkg::DEPTH_DEF,
  parameter int WORD_W = rfop_pkg::WORD_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rfop_pkg::FUNC_W-1:0]        func,
  input  logic [rfop_pkg::DATA_W-1:0]        entry_word,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfop_pkg::STATUS_W-1:0]      status,
  output logic [rfop_pkg::DATA_W-1:0]        head_word,
  output logic                               head_valid,
  output logic [rfop_pkg::COUNT_W-1:0]       entry_count,
  output logic                               full_flag,
  output logic                               empty_flag,
  output logic [rfop_pkg::CNT_W-1:0]         drops_total,
  output logic [rfop_pkg::CNT_W-1:0]         deliveries_total,
  // configuration port
  input  logic                               cfg_we,
  input  logic [rfop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfop_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [rfop_pkg::CAP_W-1:0]    usable_capacity;
  logic [rfop_pkg::POLICY_W-1:0] full_policy;

  // Queue state
  logic [IDX_W-1:0]             read_index, read_index_next;
  logic [IDX_W-1:0]             write_index, write_index_next;
  logic [rfop_pkg::COUNT_W-1:0] fill_level, fill_level_next;
  logic [rfop_pkg::CNT_W-1:0]   drop_counter, drop_counter_next;
  logic [rfop_pkg::CNT_W-1:0]   deliver_counter, deliver_counter_next;

  // Input register
  logic                         req_valid;
  logic [rfop_pkg::FUNC_W-1:0]  req_func;
  logic [rfop_pkg::DATA_W-1:0]  req_word;

  // Result register
  logic                         head_hit;
  logic [WORD_W-1:0]            head_byp;

  logic                         req_adv;
  logic [rfop_pkg::CAP_W-1:0]   cap;
  logic [rfop_pkg::STATUS_W-1:0] status_next;
  logic                         store_we;
  logic [WORD_W-1:0]            store_wdata;
  logic [WORD_W-1:0]            store_rdata;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [rfop_pkg::CAP_W-1:0] c);
    logic [31:0] n;
    n = 32'(idx) + 32'd1;
    return (n >= 32'(c)) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [rfop_pkg::CNT_W-1:0] bump(input logic [rfop_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Effective capacity: zero acts as one, clamp to store depth
  always_comb begin
    priority if (usable_capacity == '0) begin
      cap = rfop_pkg::CAP_W'(1);
    end else if (32'(usable_capacity) > DEPTH) begin
      cap = rfop_pkg::CAP_W'(DEPTH);
    end else begin
      cap = usable_capacity;
    end
  end

  // Move the request on when the result register is free or being taken
  assign req_adv  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !req_adv;

  assign store_wdata = WORD_W'(req_word);

  // Next queue state for the request in the input register
  always_comb begin
    status_next          = rfop_pkg::STATUS_OK;
    read_index_next      = read_index;
    write_index_next     = write_index;
    fill_level_next      = fill_level;
    drop_counter_next    = drop_counter;
    deliver_counter_next = deliver_counter;
    store_we             = 1'b0;
    unique case (req_func)
      rfop_pkg::FUNC_ADD: begin
        store_we = 1'b1;
        if (fill_level >= cap) begin
          priority if (full_policy == rfop_pkg::POLICY_DROP_OLDEST) begin
            // drop the oldest entry, then accept
            read_index_next   = advance(read_index, cap);
            fill_level_next   = fill_level - 1'b1;
            drop_counter_next = bump(drop_counter);
          end else if (full_policy == rfop_pkg::POLICY_REJECT_CNT) begin
            drop_counter_next = bump(drop_counter);
            status_next       = rfop_pkg::STATUS_FULL;
            store_we          = 1'b0;
          end else begin
            status_next = rfop_pkg::STATUS_FULL;
            store_we    = 1'b0;
          end
        end
        if (store_we) begin
          write_index_next = advance(write_index, cap);
          fill_level_next  = fill_level_next + 1'b1;
        end
      end
      rfop_pkg::FUNC_REMOVE: begin
        if (fill_level == '0) begin
          status_next = rfop_pkg::STATUS_EMPTY;
        end else begin
          read_index_next      = advance(read_index, cap);
          fill_level_next      = fill_level - 1'b1;
          deliver_counter_next = bump(deliver_counter);
        end
      end
      rfop_pkg::FUNC_CLEAR: begin
        read_index_next  = '0;
        write_index_next = '0;
        fill_level_next  = '0;
      end
      rfop_pkg::FUNC_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Entry store: write the added word, read the new head
  rfop_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (req_adv && store_we),
    .waddr (write_index),
    .wdata (store_wdata),
    .re    (req_adv),
    .raddr (read_index_next),
    .rdata (store_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_capacity <= rfop_pkg::CAPACITY_RST;
      full_policy     <= rfop_pkg::POLICY_RST;
    end else if (cfg_we) begin
      if (cfg_index == rfop_pkg::REG_CAPACITY) begin
        usable_capacity <= cfg_data;
      end else if (cfg_index == rfop_pkg::REG_POLICY) begin
        full_policy <= cfg_data[rfop_pkg::POLICY_W-1:0];
      end
    end
  end

  // Input register: load a request when empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req_func <= func;
      req_word <= entry_word;
    end
  end

  // Commit queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index      <= '0;
      write_index     <= '0;
      fill_level      <= '0;
      drop_counter    <= '0;
      deliver_counter <= '0;
    end else if (req_adv) begin
      read_index      <= read_index_next;
      write_index     <= write_index_next;
      fill_level      <= fill_level_next;
      drop_counter    <= drop_counter_next;
      deliver_counter <= deliver_counter_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; bypass the store when the head is written this cycle
  always_ff @(posedge clk) begin
    if (req_adv) begin
      status           <= status_next;
      head_valid       <= (fill_level_next != '0);
      empty_flag       <= (fill_level_next == '0);
      entry_count      <= fill_level_next;
      full_flag        <= (fill_level_next >= cap);
      drops_total      <= drop_counter_next;
      deliveries_total <= deliver_counter_next;
      head_hit         <= store_we && (write_index == read_index_next);
      head_byp         <= store_wdata;
    end
  end

  // Head word, zero when the queue is empty
  always_comb begin
    if (!head_valid) begin
      head_word = '0;
    end else if (head_hit) begin
      head_word = rfop_pkg::DATA_W'(head_byp);
    end else begin
      head_word = rfop_pkg::DATA_W'(store_rdata);
    end
  end

endmodule
